/* hw/rtl/ipv4rf_pkg.sv */
// ipv4rf_pkg: shared types, verdict codes and register indexes of the ipv4 receive filter
// used by every module in hw/rtl; depends on nothing

package ipv4rf_pkg;

	localparam int PROTO_SLOTS_DEF = 4;
	localparam int SLOT_REGS       = 4;
	localparam int SLOT_REG_W      = 9;
	localparam int SLOT_VALID_BIT  = 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_IFACE  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOCAL  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_0 = 3'd3;

	localparam int QDEPTH = 2;
	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	localparam logic [15:0] COUNT_MAX   = 16'hffff;
	localparam logic [15:0] MIN_HEADER  = 16'd20;
	localparam logic [15:0] SUM_GOOD    = 16'hffff;
	localparam logic [15:0] MF_FLAG     = 16'h2000;
	localparam logic [15:0] OFFSET_MASK = 16'h1fff;
	localparam logic [3:0]  IP_VERSION  = 4'd4;
	localparam logic [31:0] ALL_ONES    = 32'hffffffff;

	localparam logic [3:0] VERDICT_DELIVER   = 4'd0;
	localparam logic [3:0] VERDICT_SHORT     = 4'd1;
	localparam logic [3:0] VERDICT_VERSION   = 4'd2;
	localparam logic [3:0] VERDICT_HLEN      = 4'd3;
	localparam logic [3:0] VERDICT_CKSUM     = 4'd4;
	localparam logic [3:0] VERDICT_TOTAL     = 4'd5;
	localparam logic [3:0] VERDICT_FRAG      = 4'd6;
	localparam logic [3:0] VERDICT_NOIFACE   = 4'd7;
	localparam logic [3:0] VERDICT_OTHERHOST = 4'd8;
	localparam logic [3:0] VERDICT_UNR_ICMP  = 4'd9;
	localparam logic [3:0] VERDICT_UNR_QUIET = 4'd10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic [7:0]  protocol_number;
		logic [1:0]  matched_slot;
		logic [5:0]  header_bytes;
		logic [15:0] payload_length;
		logic [31:0] source_address;
		logic [6:0]  icmp_quote_bytes;
	} result_item_t;

	// per-packet summary handed from the front to the back
	typedef struct packed {
		logic [3:0]  check;
		logic [3:0]  ihl;
		logic [15:0] total_length;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
	} hdr_t;

endpackage

/* hw/rtl/ipv4rf_front.sv */
// ipv4rf_front: byte-wise header capture, ones-complement sum, byte count and header checks
// depends on ipv4rf_pkg; pushes one summary per packet into ipv4rf_fifo

module ipv4rf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_ready,
	input  ipv4rf_pkg::byte_item_t  byte_item,
	input  logic                    full,
	output logic                    push,
	output ipv4rf_pkg::hdr_t        push_hdr
);

	localparam logic [15:0] OFS_VER    = 16'd0;
	localparam logic [15:0] OFS_TOT_HI = 16'd2;
	localparam logic [15:0] OFS_TOT_LO = 16'd3;
	localparam logic [15:0] OFS_FRG_HI = 16'd6;
	localparam logic [15:0] OFS_FRG_LO = 16'd7;
	localparam logic [15:0] OFS_PROTO  = 16'd9;
	localparam logic [15:0] OFS_SRC_0  = 16'd12;
	localparam logic [15:0] OFS_SRC_1  = 16'd13;
	localparam logic [15:0] OFS_SRC_2  = 16'd14;
	localparam logic [15:0] OFS_SRC_3  = 16'd15;
	localparam logic [15:0] OFS_DST_0  = 16'd16;
	localparam logic [15:0] OFS_DST_1  = 16'd17;
	localparam logic [15:0] OFS_DST_2  = 16'd18;
	localparam logic [15:0] OFS_DST_3  = 16'd19;

	logic [15:0] byte_counter_q, cnt_n;
	logic [15:0] sum_q, sum_n;
	logic [7:0]  hold_q, hold_n;
	logic [7:0]  vihl_q, vihl_n;
	logic [15:0] tot_q, tot_n;
	logic [15:0] frag_q, frag_n;
	logic [7:0]  proto_q, proto_n;
	logic [31:0] src_q, src_n;
	logic [31:0] dst_q, dst_n;
	logic [5:0]  hlen_n;
	logic [16:0] sum_full;
	logic        accept;
	logic        take;
	logic [7:0]  b;
	logic [3:0]  check;

	assign b          = byte_item.data_byte;
	assign byte_ready = !byte_item.last_byte || !full;
	assign accept     = byte_valid && byte_ready;
	assign take       = accept && (byte_counter_q != ipv4rf_pkg::COUNT_MAX);
	assign push       = accept && byte_item.last_byte;

	always_comb begin
		cnt_n    = byte_counter_q;
		sum_n    = sum_q;
		hold_n   = hold_q;
		vihl_n   = vihl_q;
		tot_n    = tot_q;
		frag_n   = frag_q;
		proto_n  = proto_q;
		src_n    = src_q;
		dst_n    = dst_q;
		sum_full = {1'b0, sum_q} + {1'b0, hold_q, b};
		if (take) begin
			unique case (byte_counter_q)
				OFS_VER:    vihl_n = b;
				OFS_TOT_HI: tot_n = {b, tot_q[7:0]};
				OFS_TOT_LO: tot_n = {tot_q[15:8], b};
				OFS_FRG_HI: frag_n = {b, frag_q[7:0]};
				OFS_FRG_LO: frag_n = {frag_q[15:8], b};
				OFS_PROTO:  proto_n = b;
				OFS_SRC_0, OFS_SRC_1, OFS_SRC_2, OFS_SRC_3: src_n = {src_q[23:0], b};
				OFS_DST_0, OFS_DST_1, OFS_DST_2, OFS_DST_3: dst_n = {dst_q[23:0], b};
				default: ;
			endcase
			cnt_n = byte_counter_q + 16'd1;
		end
		hlen_n = {vihl_n[3:0], 2'b00};
		if (take && (byte_counter_q < {10'd0, hlen_n})) begin
			if (!byte_counter_q[0]) begin
				hold_n = b;
			end else begin
				sum_n = sum_full[15:0] + {15'd0, sum_full[16]};
			end
		end
	end

	always_comb begin
		priority if (cnt_n < ipv4rf_pkg::MIN_HEADER) begin
			check = ipv4rf_pkg::VERDICT_SHORT;
		end else if (vihl_n[7:4] != ipv4rf_pkg::IP_VERSION) begin
			check = ipv4rf_pkg::VERDICT_VERSION;
		end else if (cnt_n < {10'd0, hlen_n}) begin
			check = ipv4rf_pkg::VERDICT_HLEN;
		end else if (sum_n != ipv4rf_pkg::SUM_GOOD) begin
			check = ipv4rf_pkg::VERDICT_CKSUM;
		end else if (cnt_n < tot_n) begin
			check = ipv4rf_pkg::VERDICT_TOTAL;
		end else if ((frag_n & (ipv4rf_pkg::MF_FLAG | ipv4rf_pkg::OFFSET_MASK)) != 16'd0) begin
			check = ipv4rf_pkg::VERDICT_FRAG;
		end else begin
			check = ipv4rf_pkg::VERDICT_DELIVER;
		end
	end

	always_comb begin
		push_hdr.check        = check;
		push_hdr.ihl          = vihl_n[3:0];
		push_hdr.total_length = tot_n;
		push_hdr.proto        = proto_n;
		push_hdr.src          = src_n;
		push_hdr.dst          = dst_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_counter_q <= '0;
			sum_q          <= '0;
			hold_q         <= '0;
			vihl_q         <= '0;
			tot_q          <= '0;
			frag_q         <= '0;
			proto_q        <= '0;
			src_q          <= '0;
			dst_q          <= '0;
		end else if (accept) begin
			if (byte_item.last_byte) begin
				byte_counter_q <= '0;
				sum_q          <= '0;
				hold_q         <= '0;
				vihl_q         <= '0;
				tot_q          <= '0;
				frag_q         <= '0;
				proto_q        <= '0;
				src_q          <= '0;
				dst_q          <= '0;
			end else begin
				byte_counter_q <= cnt_n;
				sum_q          <= sum_n;
				hold_q         <= hold_n;
				vihl_q         <= vihl_n;
				tot_q          <= tot_n;
				frag_q         <= frag_n;
				proto_q        <= proto_n;
				src_q          <= src_n;
				dst_q          <= dst_n;
			end
		end
	end

endmodule

/* hw/rtl/ipv4rf_fifo.sv */
// ipv4rf_fifo: short queue of packet summaries between front and back
// depends on ipv4rf_pkg for the entry type and depth

module ipv4rf_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ipv4rf_pkg::hdr_t  push_hdr,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output ipv4rf_pkg::hdr_t  head
);

	ipv4rf_pkg::hdr_t                   mem_q [ipv4rf_pkg::QDEPTH];
	logic [ipv4rf_pkg::PTR_W-1:0]       wr_ptr_q;
	logic [ipv4rf_pkg::PTR_W-1:0]       rd_ptr_q;
	logic [ipv4rf_pkg::CNT_W-1:0]       count_q;

	localparam logic [ipv4rf_pkg::PTR_W-1:0] PTR_LAST = ipv4rf_pkg::PTR_W'(ipv4rf_pkg::QDEPTH - 1);
	localparam logic [ipv4rf_pkg::CNT_W-1:0] CNT_FULL = ipv4rf_pkg::CNT_W'(ipv4rf_pkg::QDEPTH);

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_hdr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_FULL)
		else $error("queue count out of range");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");
`endif

endmodule

/* hw/rtl/ipv4rf_back.sv */
// ipv4rf_back: configuration registers, address and protocol checks, registered result
// depends on ipv4rf_pkg; takes packet summaries from ipv4rf_fifo

module ipv4rf_back #(
	parameter int PROTO_SLOTS = ipv4rf_pkg::PROTO_SLOTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ipv4rf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ipv4rf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  empty,
	input  ipv4rf_pkg::hdr_t                      head,
	output logic                                  pop,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output ipv4rf_pkg::result_item_t              result_item
);

	logic                                  iface_q;
	logic [31:0]                           local_q;
	logic [31:0]                           mask_q;
	logic [ipv4rf_pkg::SLOT_REG_W-1:0]     slot_q [PROTO_SLOTS];
	logic                                  result_valid_q;
	ipv4rf_pkg::result_item_t              result_q;
	ipv4rf_pkg::result_item_t              res_n;
	logic [31:0]                           bcast;
	logic [5:0]                            hlen;
	logic [6:0]                            quote;
	logic                                  found;
	logic [1:0]                            slot_idx;

	assign pop          = !empty && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;
	assign result_item  = result_q;
	assign bcast        = (local_q & mask_q) | ~mask_q;
	assign hlen         = {head.ihl, 2'b00};
	assign quote        = {1'b0, hlen} + 7'd8;

	// lowest valid matching slot wins
	always_comb begin
		found    = 1'b0;
		slot_idx = '0;
		for (int i = PROTO_SLOTS - 1; i >= 0; i--) begin
			if (slot_q[i][ipv4rf_pkg::SLOT_VALID_BIT] && (slot_q[i][7:0] == head.proto)) begin
				found    = 1'b1;
				slot_idx = 2'(i);
			end
		end
	end

	always_comb begin
		res_n.protocol_number  = head.proto;
		res_n.header_bytes     = hlen;
		res_n.source_address   = head.src;
		res_n.matched_slot     = '0;
		res_n.payload_length   = '0;
		res_n.icmp_quote_bytes = '0;
		priority if (head.check != ipv4rf_pkg::VERDICT_DELIVER) begin
			res_n.verdict = head.check;
		end else if (!iface_q) begin
			res_n.verdict = ipv4rf_pkg::VERDICT_NOIFACE;
		end else if (head.dst != local_q && head.dst != bcast
				&& head.dst != ipv4rf_pkg::ALL_ONES) begin
			res_n.verdict = ipv4rf_pkg::VERDICT_OTHERHOST;
		end else if (found) begin
			res_n.verdict      = ipv4rf_pkg::VERDICT_DELIVER;
			res_n.matched_slot = slot_idx;
			if (head.total_length >= {10'd0, hlen}) begin
				res_n.payload_length = head.total_length - {10'd0, hlen};
			end
		end else if ({9'd0, quote} <= head.total_length) begin
			res_n.verdict          = ipv4rf_pkg::VERDICT_UNR_ICMP;
			res_n.icmp_quote_bytes = quote;
		end else begin
			res_n.verdict = ipv4rf_pkg::VERDICT_UNR_QUIET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iface_q <= 1'b0;
			local_q <= '0;
			mask_q  <= '0;
			for (int s = 0; s < PROTO_SLOTS; s++) begin
				slot_q[s] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == ipv4rf_pkg::REG_IFACE) begin
				iface_q <= cfg_data[0];
			end
			if (cfg_index == ipv4rf_pkg::REG_LOCAL) begin
				local_q <= cfg_data[31:0];
			end
			if (cfg_index == ipv4rf_pkg::REG_MASK) begin
				mask_q <= cfg_data[31:0];
			end
			for (int s = 0; s < PROTO_SLOTS; s++) begin
				if (s < ipv4rf_pkg::SLOT_REGS
						&& cfg_index == ipv4rf_pkg::CFG_INDEX_W'(int'(ipv4rf_pkg::REG_SLOT_0) + s)) begin
					slot_q[s] <= cfg_data[ipv4rf_pkg::SLOT_REG_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_n;
		end
	end

endmodule

/* hw/rtl/ipv4_receive_filter.sv */
// ipv4_receive_filter: top level of the ipv4 receive filter
// depends on ipv4rf_pkg, ipv4rf_front, ipv4rf_fifo and ipv4rf_back

// Takes one packet byte per clock with a last marker and gives one result item per packet.
// The front takes a byte every cycle, capturing header fields, summing the header and
// running the header checks on the last byte; a summary then waits in a two-entry queue
// and the back resolves interface, address and protocol slot into a registered result,
// loaded from the queue head once the result register is free. The front stalls
// only on a last byte while the queue is full, so packets sustain one byte per clock
// as long as results are taken. Registers are written through cfg_we/cfg_index/cfg_data
// while no packet is in flight: the user is bound to this, the block does not enforce it.
module ipv4_receive_filter #(
	parameter int PROTO_SLOTS = ipv4rf_pkg::PROTO_SLOTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  byte_valid,
	output logic                                  byte_ready,
	input  ipv4rf_pkg::byte_item_t                byte_item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output ipv4rf_pkg::result_item_t              result_item,
	input  logic                                  cfg_we,
	input  logic [ipv4rf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ipv4rf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic             push;
	logic             full;
	logic             pop;
	logic             empty;
	ipv4rf_pkg::hdr_t push_hdr;
	ipv4rf_pkg::hdr_t head;

	ipv4rf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.full       (full),
		.push       (push),
		.push_hdr   (push_hdr)
	);

	ipv4rf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_hdr (push_hdr),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	ipv4rf_back #(
		.PROTO_SLOTS (PROTO_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench: streams ipv4 packets byte by byte into ipv4_receive_filter and checks every verdict
// against a packet model kept here; depends on ipv4rf_pkg and the filter rtl

module testbench;
	import ipv4rf_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 8;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   byte_valid   = 1'b0;
	logic                   byte_ready;
	byte_item_t             byte_item    = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_item_t           result_item;
	logic                   cfg_we       = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	ipv4_receive_filter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item(result_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// register copy
	logic        if_up;
	logic [31:0] my_addr;
	logic [31:0] my_mask;
	logic [8:0]  proto_table [SLOT_REGS];

	// per-packet capture
	logic [15:0] rx_count;
	logic [15:0] rx_sum;
	logic [7:0]  rx_hi;
	logic [7:0]  rx_vihl;
	logic [15:0] rx_total;
	logic [15:0] rx_frag;
	logic [7:0]  rx_proto;
	logic [31:0] rx_src;
	logic [31:0] rx_dst;

	byte_item_t   wire_bytes[$];
	result_item_t pending_verdicts[$];
	result_item_t oldest;

	int fail_count   = 0;
	int cycle_count  = 0;
	int bytes_queued = 0;
	int send_gap     = 0;
	int recv_gap     = 0;
	bit send_steady  = 1'b0;
	bit recv_steady  = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic clear_rx();
		rx_count = '0;
		rx_sum   = '0;
		rx_hi    = '0;
		rx_vihl  = '0;
		rx_total = '0;
		rx_frag  = '0;
		rx_proto = '0;
		rx_src   = '0;
		rx_dst   = '0;
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		logic [16:0] s;
		logic [5:0]  hlen;
		if (rx_count != COUNT_MAX) begin
			case (rx_count)
				16'd0: rx_vihl = b;
				16'd2: rx_total[15:8] = b;
				16'd3: rx_total[7:0] = b;
				16'd6: rx_frag[15:8] = b;
				16'd7: rx_frag[7:0] = b;
				16'd9: rx_proto = b;
				16'd12, 16'd13, 16'd14, 16'd15: rx_src = {rx_src[23:0], b};
				16'd16, 16'd17, 16'd18, 16'd19: rx_dst = {rx_dst[23:0], b};
				default: ;
			endcase
			hlen = {rx_vihl[3:0], 2'b00};
			if (rx_count < hlen) begin
				if (!rx_count[0]) begin
					rx_hi = b;
				end else begin
					s = rx_sum + {rx_hi, b};
					rx_sum = s[15:0] + s[16];
				end
			end
			rx_count = rx_count + 16'd1;
		end
	endtask

	function automatic result_item_t judge_packet();
		result_item_t r;
		logic [5:0]   hlen;
		logic [31:0]  bcast;
		bit           found;
		r = '0;
		found = 1'b0;
		hlen = {rx_vihl[3:0], 2'b00};
		bcast = (my_addr & my_mask) | ~my_mask;
		r.protocol_number = rx_proto;
		r.header_bytes = hlen;
		r.source_address = rx_src;
		if (rx_count < MIN_HEADER)
			r.verdict = VERDICT_SHORT;
		else if (rx_vihl[7:4] != IP_VERSION)
			r.verdict = VERDICT_VERSION;
		else if (rx_count < hlen)
			r.verdict = VERDICT_HLEN;
		else if (rx_sum != SUM_GOOD)
			r.verdict = VERDICT_CKSUM;
		else if (rx_count < rx_total)
			r.verdict = VERDICT_TOTAL;
		else if ((rx_frag & MF_FLAG) != 0 || (rx_frag & OFFSET_MASK) != 0)
			r.verdict = VERDICT_FRAG;
		else if (!if_up)
			r.verdict = VERDICT_NOIFACE;
		else if (rx_dst != my_addr && rx_dst != bcast && rx_dst != ALL_ONES)
			r.verdict = VERDICT_OTHERHOST;
		else begin
			for (int i = 0; i < PROTO_SLOTS_DEF; i++) begin
				if (!found && proto_table[i][SLOT_VALID_BIT] && proto_table[i][7:0] == rx_proto) begin
					found = 1'b1;
					r.matched_slot = 2'(i);
				end
			end
			if (found) begin
				r.verdict = VERDICT_DELIVER;
				r.payload_length = (rx_total >= hlen) ? rx_total - hlen : 16'd0;
			end else if (hlen + 16'd8 <= rx_total) begin
				r.verdict = VERDICT_UNR_ICMP;
				r.icmp_quote_bytes = hlen + 7'd8;
			end else begin
				r.verdict = VERDICT_UNR_QUIET;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_IFACE: if_up = value[0];
			REG_LOCAL: my_addr = value;
			REG_MASK:  my_mask = value;
			default: begin
				if (idx >= REG_SLOT_0 && idx < REG_SLOT_0 + SLOT_REGS)
					proto_table[idx - REG_SLOT_0] = value[8:0];
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic iface, input logic [31:0] addr, input logic [31:0] mask);
		write_reg(REG_IFACE, {31'($urandom()), iface});
		write_reg(REG_LOCAL, addr);
		write_reg(REG_MASK, mask);
	endtask

	task automatic set_slots(input logic [8:0] s0, s1, s2, s3);
		logic [8:0] want [SLOT_REGS];
		want = '{s0, s1, s2, s3};
		for (int i = 0; i < SLOT_REGS; i++)
			write_reg(CFG_INDEX_W'(REG_SLOT_0 + i), {23'($urandom()), want[i]});
	endtask

	function automatic logic [8:0] slot_on(input logic [7:0] p);
		return {1'b1, p};
	endfunction

	// sender holds off until the filter has nothing in flight
	task automatic wait_idle();
		while (wire_bytes.size() != 0 || byte_valid || pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_packet(input logic [3:0] ver, input logic [3:0] ihl,
			input logic [15:0] total, input int wire_len, input logic [15:0] frag,
			input logic [7:0] prot, input logic [31:0] dst, input bit good_sum);
		logic [7:0]  pkt [];
		logic [16:0] s;
		logic [15:0] acc;
		logic [31:0] src;
		byte_item_t  it;
		int          n;
		int          hl;
		hl = ihl * 4;
		n = (wire_len < 60) ? 60 : wire_len;
		src = $urandom();
		pkt = new[n];
		foreach (pkt[i])
			pkt[i] = 8'($urandom());
		pkt[0] = {ver, ihl};
		pkt[2] = total[15:8];
		pkt[3] = total[7:0];
		pkt[6] = frag[15:8];
		pkt[7] = frag[7:0];
		pkt[9] = prot;
		for (int k = 0; k < 4; k++) begin
			pkt[12 + k] = src[31 - 8 * k -: 8];
			pkt[16 + k] = dst[31 - 8 * k -: 8];
		end
		if (hl >= 12) begin
			pkt[10] = 8'd0;
			pkt[11] = 8'd0;
			acc = 16'd0;
			for (int k = 0; k < hl; k += 2) begin
				s = acc + {pkt[k], pkt[k + 1]};
				acc = s[15:0] + s[16];
			end
			acc = ~acc;
			if (!good_sum)
				acc = acc ^ (16'd1 << $urandom_range(0, 15));
			pkt[10] = acc[15:8];
			pkt[11] = acc[7:0];
		end
		for (int k = 0; k < wire_len; k++) begin
			it.data_byte = pkt[k];
			it.last_byte = (k == wire_len - 1);
			wire_bytes.push_back(it);
		end
		bytes_queued += wire_len;
	endtask

	// mostly well-formed headers with random content, one fault injected now and then
	task automatic push_random_packet();
		logic [3:0]  ver;
		logic [3:0]  ihl;
		logic [15:0] total;
		logic [15:0] frag;
		logic [7:0]  prot;
		logic [31:0] dst;
		int          wire_len;
		bit          good_sum;
		ver = IP_VERSION;
		ihl = 4'($urandom_range(5, 7));
		if ($urandom_range(0, 7) == 0)
			ihl = 4'($urandom_range(8, 15));
		total = 16'(ihl * 4 + $urandom_range(0, 12));
		wire_len = total + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
		frag = 16'd0;
		good_sum = 1'b1;
		prot = ($urandom_range(0, 3) != 0) ? proto_table[$urandom_range(0, 3)][7:0] : 8'($urandom());
		case ($urandom_range(0, 5))
			0: dst = (my_addr & my_mask) | ~my_mask;
			1: dst = ALL_ONES;
			2: dst = $urandom();
			default: dst = my_addr;
		endcase
		case ($urandom_range(0, 19))
			0: ver = 4'($urandom());
			1: ihl = 4'($urandom());
			2: good_sum = 1'b0;
			3: total = total + 16'($urandom_range(1, 20));
			4: frag = 16'($urandom()) & (MF_FLAG | OFFSET_MASK);
			5: wire_len = $urandom_range(1, 24);
			6: total = 16'($urandom_range(0, total));
			7: frag = 16'($urandom()) & ~(MF_FLAG | OFFSET_MASK);
			8: begin
				ver = 4'($urandom());
				ihl = 4'($urandom());
				total = 16'($urandom());
				good_sum = $urandom_range(0, 1);
			end
			default: ;
		endcase
		push_packet(ver, ihl, total, wire_len, frag, prot, dst, good_sum);
	endtask

	// byte side
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				absorb_byte(byte_item.data_byte);
				if (byte_item.last_byte) begin
					pending_verdicts.push_back(judge_packet());
					clear_rx();
				end
			end
			if (!byte_valid || byte_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					byte_valid <= 1'b0;
				end else if (wire_bytes.size() != 0) begin
					byte_item <= wire_bytes.pop_front();
					byte_valid <= 1'b1;
					if ($urandom_range(0, 99) == 0)
						send_steady = !send_steady;
					send_gap = send_steady ? 0 : $urandom_range(0, 10);
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("result item with no packet waiting, verdict %0d", result_item.verdict);
					fail_count++;
				end else begin
					oldest = pending_verdicts.pop_front();
					check_field("verdict", oldest.verdict, result_item.verdict);
					check_field("protocol_number", oldest.protocol_number, result_item.protocol_number);
					check_field("matched_slot", oldest.matched_slot, result_item.matched_slot);
					check_field("header_bytes", oldest.header_bytes, result_item.header_bytes);
					check_field("payload_length", oldest.payload_length, result_item.payload_length);
					check_field("source_address", oldest.source_address, result_item.source_address);
					check_field("icmp_quote_bytes", oldest.icmp_quote_bytes,
						result_item.icmp_quote_bytes);
				end
				if ($urandom_range(0, 31) == 0)
					recv_steady = !recv_steady;
				recv_gap = recv_steady ? 0 : $urandom_range(0, 10);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] home;
		logic [31:0] bcast;
		int          base;
		int          pkts;
		home = 32'h0a000005;
		if_up = 1'b0;
		my_addr = '0;
		my_mask = '0;
		foreach (proto_table[i])
			proto_table[i] = '0;
		clear_rx();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers still at reset: no interface
		push_packet(IP_VERSION, 4'd5, 16'd20, 20, 16'd0, 8'd6, 32'd0, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd20, 19, 16'd0, 8'd6, 32'd0, 1'b1);
		wait_idle();

		configure(1'b1, home, 32'hffffff00);
		set_slots(slot_on(8'd6), slot_on(8'd17), 9'd1, slot_on(8'd17));
		write_reg(CFG_INDEX_W'(REG_SLOT_0 + SLOT_REGS), $urandom());
		bcast = (home & 32'hffffff00) | ~32'hffffff00;
		push_packet(IP_VERSION, 4'd5, 16'd20, 1, 16'd0, 8'd17, home, 1'b1);
		push_packet(4'd6, 4'd5, 16'd20, 20, 16'd0, 8'd17, home, 1'b1);
		push_packet(IP_VERSION, 4'd15, 16'd60, 40, 16'd0, 8'd17, home, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd20, 20, 16'd0, 8'd17, home, 1'b0);
		push_packet(IP_VERSION, 4'd5, 16'd100, 30, 16'd0, 8'd17, home, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd20, 20, MF_FLAG, 8'd17, home, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd20, 20, OFFSET_MASK, 8'd17, home, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd20, 20, 16'h4000, 8'd17, home, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd20, 20, 16'd0, 8'd17, home + 32'd1, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd28, 28, 16'd0, 8'd17, home, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd20, 20, 16'd0, 8'd6, bcast, 1'b1);
		push_packet(IP_VERSION, 4'd15, 16'd64, 64, 16'd0, 8'd17, ALL_ONES, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd28, 28, 16'd0, 8'd1, home, 1'b1);
		push_packet(IP_VERSION, 4'd15, 16'd68, 68, 16'd0, 8'd1, home, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd27, 27, 16'd0, 8'd1, home, 1'b1);
		// short ihl still summed over its own length; zero ihl never sums right
		push_packet(IP_VERSION, 4'd4, 16'd20, 20, 16'd0, 8'd6, home, 1'b1);
		push_packet(IP_VERSION, 4'd0, 16'd20, 20, 16'd0, 8'd6, home, 1'b1);
		// total below header length
		push_packet(IP_VERSION, 4'd6, 16'd20, 24, 16'd0, 8'd17, home, 1'b1);
		push_packet(IP_VERSION, 4'd5, 16'd0, 20, 16'd0, 8'd17, home, 1'b1);
		wait_idle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					configure(1'b1, $urandom(), 32'hffffff00);
					set_slots(9'($urandom()), 9'($urandom()), 9'($urandom()), 9'($urandom()));
				end
				1: begin
					configure(1'b1, 32'd0, 32'd0);
					set_slots(slot_on(8'd0), slot_on(8'd255), slot_on(8'd6), slot_on(8'd17));
				end
				2: begin
					configure(1'b1, ALL_ONES, ALL_ONES);
					set_slots(9'd6, 9'd17, 9'd0, 9'd255);
				end
				default: begin
					configure($urandom_range(0, 1), $urandom(), ALL_ONES << $urandom_range(0, 32));
					set_slots(9'($urandom()), 9'($urandom()), slot_on(8'($urandom())),
						9'($urandom()));
				end
			endcase
			base = bytes_queued;
			pkts = 0;
			while (bytes_queued < base + 140 || pkts < 4) begin
				push_random_packet();
				pkts++;
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
